@@ rtl/gct_pkg.sv @@
`default_nettype none
package gct_pkg;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned WEIGHT_W = 17;
	localparam int unsigned NBINS_W = 11;
	localparam int unsigned LIMIT_W = 5;
	localparam int unsigned BIN_BITS = 10;
	localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = 17'd65536;

	localparam logic [1:0] OUT_KEPT = 2'd0;
	localparam logic [1:0] OUT_INSERTED = 2'd1;
	localparam logic [1:0] OUT_REPLACED = 2'd2;
	localparam logic [1:0] OUT_DISCARDED = 2'd3;

	localparam logic [2:0] REG_LOWER_0 = 3'd0;
	localparam logic [2:0] REG_UPPER_0 = 3'd1;
	localparam logic [2:0] REG_LOWER_1 = 3'd2;
	localparam logic [2:0] REG_UPPER_1 = 3'd3;
	localparam logic [2:0] REG_TARGET = 3'd4;
	localparam logic [2:0] REG_NBINS = 3'd5;
	localparam logic [2:0] REG_LIMIT = 3'd6;
	localparam logic [2:0] REG_DIMS = 3'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_0;
		logic signed [COORD_W-1:0] coord_1;
		logic [COORD_W-1:0] measured;
	} sample_t;

	typedef struct packed {
		logic [9:0] bin_index_0;
		logic [9:0] bin_index_1;
		logic [WEIGHT_W-1:0] sample_weight;
		logic [1:0] outcome;
		logic out_of_range;
		logic [4:0] cells_held;
		logic [WEIGHT_W-1:0] worst_weight;
	} result_t;

	typedef struct packed {
		logic [BIN_BITS-1:0] bin_0;
		logic [BIN_BITS-1:0] bin_1;
		logic [WEIGHT_W-1:0] weight;
		logic flag;
	} job_t;
endpackage
`default_nettype wire

@@ rtl/gct_if.sv @@
`default_nettype none
interface gct_sample_if;
	import gct_pkg::*;
	logic valid;
	logic ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gct_result_if;
	import gct_pkg::*;
	logic valid;
	logic ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gct_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/gct_front.sv @@
`default_nettype none
module gct_front import gct_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire sample_t in_data,
	input wire logic signed [31:0] lower_0,
	input wire logic signed [31:0] upper_0,
	input wire logic signed [31:0] lower_1,
	input wire logic signed [31:0] upper_1,
	input wire logic [31:0] target,
	input wire logic [10:0] nbins,
	input wire logic [1:0] dims,
	output logic job_valid,
	input wire logic job_ready,
	output job_t job
);
	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_BIN0 = 3'd1;
	localparam logic [2:0] F_BIN1 = 3'd2;
	localparam logic [2:0] F_RAT = 3'd3;
	localparam logic [2:0] F_SQ = 3'd4;
	localparam logic [2:0] F_OUT = 3'd5;

	logic [2:0] state_q;
	sample_t smp_q;
	logic [10:0] nb_q;
	logic two_q;
	logic [5:0] cnt_q;
	logic [43:0] num_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [43:0] quo_q;
	logic [9:0] bin0_q, bin1_q;
	logic flag_q;
	logic [16:0] r_q;
	logic [16:0] w_q;
	logic [32:0] trial;
	logic [33:0] rem_sh;

	logic signed [32:0] d_diff, d_span;
	logic dflag, dzero;
	logic [10:0] nbe;

	always_comb begin
		nbe = (nbins == 11'd0) ? 11'd1 : ((nbins > 11'd1024) ? 11'd1024 : nbins);
	end

	assign in_ready = (state_q == F_IDLE);
	assign rem_sh = {rem_q, num_q[43]};
	assign trial = rem_sh[32:0] - den_q;

	always_comb begin
		if (state_q == F_IDLE || state_q == F_BIN0) begin
			d_diff = {smp_q.coord_0[31], smp_q.coord_0} - {lower_0[31], lower_0};
			d_span = {upper_0[31], upper_0} - {lower_0[31], lower_0};
		end else begin
			d_diff = {smp_q.coord_1[31], smp_q.coord_1} - {lower_1[31], lower_1};
			d_span = {upper_1[31], upper_1} - {lower_1[31], lower_1};
		end
		dflag = (d_span <= 33'sd0) || (d_diff < 33'sd0);
		dzero = dflag || (d_diff == 33'sd0);
	end

	logic [43:0] quo_n;
	logic [9:0] bin_res;
	logic bin_sat;
	always_comb begin
		quo_n = {quo_q[42:0], (rem_sh[33] || rem_sh[32:0] >= den_q)};
		bin_sat = (quo_n >= {33'd0, nb_q});
		bin_res = bin_sat ? 10'(nb_q - 11'd1) : quo_n[9:0];
	end

	function automatic logic [43:0] bin_num(input logic signed [32:0] df,
			input logic [10:0] n);
		logic [43:0] p;
		p = 44'(df[31:0]) * 44'(n);
		return p - 44'd1;
	endfunction

	logic [31:0] sm, lg;
	always_comb begin
		sm = (smp_q.measured < target) ? smp_q.measured : target;
		lg = (smp_q.measured < target) ? target : smp_q.measured;
	end

	logic [33:0] sq;
	assign sq = 34'(r_q) * 34'(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						smp_q <= in_data;
						nb_q <= nbe;
						two_q <= (dims >= 2'd2);
						flag_q <= 1'b0;
						bin0_q <= '0;
						bin1_q <= '0;
						state_q <= F_BIN0;
						cnt_q <= '0;
					end
				end
				F_BIN0, F_BIN1: begin
					if (cnt_q == 6'd0) begin
						if (dzero) begin
							flag_q <= flag_q | dflag;
							if (state_q == F_BIN0 && two_q) state_q <= F_BIN1;
							else begin
								state_q <= F_RAT;
								cnt_q <= '0;
							end
						end else begin
							num_q <= bin_num(d_diff, nb_q);
							den_q <= 33'(d_span);
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= 6'd1;
						end
					end else begin
						num_q <= {num_q[42:0], 1'b0};
						rem_q <= (rem_sh[33] || rem_sh[32:0] >= den_q) ? trial : rem_sh[32:0];
						quo_q <= quo_n;
						if (cnt_q == 6'd44) begin
							cnt_q <= '0;
							flag_q <= flag_q | bin_sat;
							if (state_q == F_BIN0) begin
								bin0_q <= bin_res;
								if (two_q) state_q <= F_BIN1;
								else state_q <= F_RAT;
							end else begin
								bin1_q <= bin_res;
								state_q <= F_RAT;
							end
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				F_RAT: begin
					if (cnt_q == 6'd0) begin
						if (lg == 32'd0) begin
							w_q <= FULL_WEIGHT;
							state_q <= F_OUT;
						end else begin
							num_q <= {sm, 12'd0};
							den_q <= {1'b0, lg};
							rem_q <= '0;
							quo_q <= '0;
							cnt_q <= 6'd1;
						end
					end else begin
						num_q <= {num_q[42:0], 1'b0};
						rem_q <= (rem_sh[33] || rem_sh[32:0] >= den_q) ? trial : rem_sh[32:0];
						quo_q <= quo_n;
						if (cnt_q == 6'd48) begin
							cnt_q <= '0;
							r_q <= quo_n[16:0];
							state_q <= F_SQ;
						end else cnt_q <= cnt_q + 6'd1;
					end
				end
				F_SQ: begin
					w_q <= sq[32:16];
					state_q <= F_OUT;
				end
				F_OUT: begin
					if (job_ready) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign job_valid = (state_q == F_OUT);
	assign job = '{bin_0: bin0_q, bin_1: bin1_q, weight: w_q, flag: flag_q};
endmodule
`default_nettype wire

@@ rtl/gct_queue.sv @@
`default_nettype none
module gct_queue import gct_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire job_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output job_t rd_data
);
	job_t mem_q [2];
	logic [1:0] wp_q, rp_q;
	logic [1:0] used;

	assign used = wp_q - rp_q;
	assign wr_ready = (used != 2'd2);
	assign rd_valid = (used != 2'd0);
	assign rd_data = mem_q[rp_q[0]];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) mem_q[wp_q[0]] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (wr_valid && wr_ready) wp_q <= wp_q + 2'd1;
			if (rd_valid && rd_ready) rp_q <= rp_q + 2'd1;
		end
	end
endmodule
`default_nettype wire

@@ rtl/gct_back.sv @@
`default_nettype none
module gct_back import gct_pkg::*; #(
	parameter int unsigned SLOTS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_ready,
	input wire job_t job,
	input wire logic [4:0] limit,
	output logic res_valid,
	input wire logic res_ready,
	output result_t res
);
	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned KW = 2 * BIN_BITS;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SRCH = 3'd1;
	localparam logic [2:0] B_ACT = 3'd2;
	localparam logic [2:0] B_SCAN = 3'd3;
	localparam logic [2:0] B_OUT = 3'd4;

	logic [KW-1:0] key_q [SLOTS];
	logic [WEIGHT_W-1:0] wt_q [SLOTS];
	logic [SLOTS-1:0] valid_q;
	logic [CW-1:0] held_q;
	logic [SW-1:0] worst_slot_q;
	logic [WEIGHT_W-1:0] worst_q;

	logic [2:0] state_q;
	job_t job_q;
	logic [KW-1:0] key_cur;
	logic [CW-1:0] idx_q;
	logic hit_q, free_q;
	logic [SW-1:0] hit_slot_q, free_slot_q;
	logic [1:0] outc_q;
	logic any_q;
	logic [WEIGHT_W-1:0] best_q;
	logic [SW-1:0] bslot_q;
	logic [CW-1:0] lim;
	logic [SW-1:0] ix;

	assign ix = idx_q[SW-1:0];
	assign key_cur = {job_q.bin_1, job_q.bin_0};
	always_comb begin
		lim = (limit == 5'd0) ? CW'(1) : ((32'(limit) > SLOTS) ? CW'(SLOTS) : CW'(limit));
	end

	assign job_ready = (state_q == B_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= '0;
			held_q <= '0;
			worst_slot_q <= '0;
			worst_q <= FULL_WEIGHT;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						idx_q <= '0;
						state_q <= B_SRCH;
					end
				end
				B_SRCH: begin
					if (valid_q[ix] && key_q[ix] == key_cur && !hit_q) begin
						hit_q <= 1'b1;
						hit_slot_q <= ix;
					end
					if (!valid_q[ix] && !free_q) begin
						free_q <= 1'b1;
						free_slot_q <= ix;
					end
					if (32'(idx_q) == SLOTS - 1) state_q <= B_ACT;
					else idx_q <= idx_q + CW'(1);
				end
				B_ACT: begin
					idx_q <= '0;
					any_q <= 1'b0;
					best_q <= FULL_WEIGHT;
					bslot_q <= '0;
					state_q <= B_SCAN;
					if (hit_q) begin
						if (job_q.weight > wt_q[hit_slot_q]) wt_q[hit_slot_q] <= job_q.weight;
						outc_q <= OUT_KEPT;
					end else if (held_q < lim) begin
						if (free_q) begin
							valid_q[free_slot_q] <= 1'b1;
							key_q[free_slot_q] <= key_cur;
							wt_q[free_slot_q] <= job_q.weight;
							held_q <= held_q + CW'(1);
							outc_q <= OUT_INSERTED;
						end else begin
							outc_q <= OUT_DISCARDED;
							state_q <= B_OUT;
						end
					end else if (held_q != '0 && job_q.weight > worst_q
							&& valid_q[worst_slot_q]) begin
						key_q[worst_slot_q] <= key_cur;
						wt_q[worst_slot_q] <= job_q.weight;
						outc_q <= OUT_REPLACED;
					end else begin
						outc_q <= OUT_DISCARDED;
						state_q <= B_OUT;
					end
				end
				B_SCAN: begin
					if (valid_q[ix] && (!any_q || wt_q[ix] < best_q)) begin
						any_q <= 1'b1;
						best_q <= wt_q[ix];
						bslot_q <= ix;
					end
					if (32'(idx_q) == SLOTS - 1) begin
						if (valid_q[ix] && (!any_q || wt_q[ix] < best_q)) begin
							worst_q <= wt_q[ix];
							worst_slot_q <= ix;
						end else begin
							worst_q <= best_q;
							worst_slot_q <= bslot_q;
						end
						state_q <= B_OUT;
					end else idx_q <= idx_q + CW'(1);
				end
				B_OUT: begin
					if (res_ready) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign res_valid = (state_q == B_OUT);
	assign res = '{bin_index_0: job_q.bin_0, bin_index_1: job_q.bin_1,
		sample_weight: job_q.weight, outcome: outc_q, out_of_range: job_q.flag,
		cells_held: 5'(held_q), worst_weight: worst_q};
endmodule
`default_nettype wire

@@ rtl/grid_cell_top_n_tracker.sv @@
// Grid-cell top-N tracker. The front unit bins one or both coordinates and forms
// the Q1.16 weight with a shared radix-2 divider: each bin division is a setup
// plus 44 steps, the ratio a setup plus 48 steps, then a squaring state. Unused
// bins, bins at or below the lower edge or with an empty span, and a zero target
// with a zero measurement skip their division. The front takes a new sample only
// after handing off the last; the slower unit sets the sample rate. A two-entry
// queue hands classified samples to the table unit, which searches the slots one
// per cycle, updates, and rescans for the worst cell; a discarded sample skips
// the rescan. Configuration writes are always accepted.
`default_nettype none
module grid_cell_top_n_tracker import gct_pkg::*; #(
	parameter int unsigned TABLE_SLOTS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	gct_sample_if.sink sample,
	gct_result_if.source result,
	gct_cfg_if.sink cfg
);
	logic signed [31:0] lower_0_q, upper_0_q, lower_1_q, upper_1_q;
	logic [31:0] target_q;
	logic [10:0] nbins_q;
	logic [4:0] limit_q;
	logic [1:0] dims_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_0_q <= '0;
			upper_0_q <= 32'sd65536;
			lower_1_q <= '0;
			upper_1_q <= 32'sd65536;
			target_q <= 32'd65536;
			nbins_q <= 11'd16;
			limit_q <= 5'd16;
			dims_q <= 2'd2;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LOWER_0: lower_0_q <= cfg.wdata;
				REG_UPPER_0: upper_0_q <= cfg.wdata;
				REG_LOWER_1: lower_1_q <= cfg.wdata;
				REG_UPPER_1: upper_1_q <= cfg.wdata;
				REG_TARGET: target_q <= cfg.wdata;
				REG_NBINS: nbins_q <= cfg.wdata[10:0];
				REG_LIMIT: limit_q <= cfg.wdata[4:0];
				REG_DIMS: dims_q <= cfg.wdata[1:0];
				default: ;
			endcase
		end
	end

	logic f_valid, f_ready, q_valid, q_ready;
	job_t f_job, q_job;

	gct_front u_front (
		.clk, .arst_n,
		.in_valid(sample.valid), .in_ready(sample.ready), .in_data(sample.data),
		.lower_0(lower_0_q), .upper_0(upper_0_q),
		.lower_1(lower_1_q), .upper_1(upper_1_q),
		.target(target_q), .nbins(nbins_q), .dims(dims_q),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	gct_queue u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);

	gct_back #(.SLOTS(TABLE_SLOTS)) u_back (
		.clk, .arst_n,
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.limit(limit_q),
		.res_valid(result.valid), .res_ready(result.ready), .res(result.data)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.cells_held <= 5'(TABLE_SLOTS))
		else $error("held count beyond table size");
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.outcome == OUT_INSERTED
		|-> result.data.cells_held != 5'd0)
		else $error("insert left table empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.worst_weight <= FULL_WEIGHT)
		else $error("worst weight above full scale");
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import gct_pkg::*;

	logic clk;
	logic arst_n;

	gct_sample_if sample ();
	gct_result_if result ();
	gct_cfg_if cfg ();

	grid_cell_top_n_tracker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result),
		.cfg(cfg)
	);

	logic [31:0] edge_lo [2];
	logic [31:0] edge_hi [2];
	logic [31:0] target_q16;
	logic [10:0] bin_count;
	logic [4:0] keep_limit;
	logic [1:0] dim_count;

	logic [19:0] slot_key [16];
	logic [16:0] slot_weight [16];
	bit slot_valid [16];
	int unsigned held;
	int unsigned low_slot;
	logic [16:0] low_weight;

	result_t pending_results [$];
	int unsigned errors;
	int unsigned results_seen;
	int unsigned outcome_seen [4];
	int unsigned flagged_seen;
	int unsigned beats_sent;

	int unsigned burst_left;
	bit long_stall_req;
	int unsigned long_stall_left;
	int unsigned stall_phase;
	bit stall_mode;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("grid_cell_top_n_tracker test failed");
		$finish;
	end

	function automatic logic [9:0] bin_of(logic [31:0] c, int d, longint unsigned n,
			inout bit flag);
		longint diff, span;
		longint unsigned q;
		diff = longint'($signed(c)) - longint'($signed(edge_lo[d]));
		span = longint'($signed(edge_hi[d])) - longint'($signed(edge_lo[d]));
		if (span <= 0) begin
			flag = 1'b1;
			return '0;
		end
		if (diff < 0) begin
			flag = 1'b1;
			return '0;
		end
		if (diff == 0)
			return '0;
		q = ($unsigned(diff) * n - 1) / $unsigned(span);
		if (q >= n) begin
			flag = 1'b1;
			return 10'(n - 1);
		end
		return 10'(q);
	endfunction

	function automatic logic [16:0] weight_of(logic [31:0] meas);
		longint unsigned t, m, lesser, greater, r;
		t = target_q16;
		m = meas;
		lesser = (m < t) ? m : t;
		greater = (m < t) ? t : m;
		if (greater == 0)
			return FULL_WEIGHT;
		r = (lesser << 16) / greater;
		return 17'((r * r) >> 16);
	endfunction

	function automatic void find_lowest();
		bit any;
		any = 1'b0;
		low_weight = FULL_WEIGHT;
		low_slot = 0;
		for (int i = 0; i < 16; i++)
			if (slot_valid[i] && (!any || slot_weight[i] < low_weight)) begin
				low_weight = slot_weight[i];
				low_slot = i;
				any = 1'b1;
			end
	endfunction

	function automatic result_t track_cell(sample_t s);
		result_t res;
		longint unsigned n;
		int unsigned dims, lim;
		int hit;
		int free_slot;
		bit flag;
		logic [9:0] b0, b1;
		logic [16:0] w;
		logic [19:0] key;
		n = bin_count;
		if (n == 0) n = 1;
		if (n > 1024) n = 1024;
		dims = dim_count;
		if (dims == 0) dims = 1;
		if (dims > 2) dims = 2;
		lim = keep_limit;
		if (lim == 0) lim = 1;
		if (lim > 16) lim = 16;
		flag = 1'b0;
		b0 = bin_of(s.coord_0, 0, n, flag);
		b1 = '0;
		if (dims == 2)
			b1 = bin_of(s.coord_1, 1, n, flag);
		w = weight_of(s.measured);
		key = {b1, b0};
		hit = -1;
		for (int i = 0; i < 16; i++)
			if (hit < 0 && slot_valid[i] && slot_key[i] == key)
				hit = i;
		res.outcome = OUT_DISCARDED;
		if (hit >= 0) begin
			if (w > slot_weight[hit])
				slot_weight[hit] = w;
			res.outcome = OUT_KEPT;
			find_lowest();
		end else if (held < lim) begin
			free_slot = -1;
			for (int i = 15; i >= 0; i--)
				if (!slot_valid[i])
					free_slot = i;
			if (free_slot >= 0) begin
				slot_valid[free_slot] = 1'b1;
				slot_key[free_slot] = key;
				slot_weight[free_slot] = w;
				held++;
				res.outcome = OUT_INSERTED;
				find_lowest();
			end
		end else if (held > 0 && w > low_weight && slot_valid[low_slot]) begin
			slot_key[low_slot] = key;
			slot_weight[low_slot] = w;
			res.outcome = OUT_REPLACED;
			find_lowest();
		end
		res.bin_index_0 = b0;
		res.bin_index_1 = b1;
		res.sample_weight = w;
		res.out_of_range = flag;
		res.cells_held = 5'(held);
		res.worst_weight = low_weight;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			result.ready <= 1'b0;
			long_stall_left <= 0;
			stall_phase <= 0;
			stall_mode <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result.data);
					errors++;
				end else begin
					exp_r = pending_results.pop_front();
					results_seen++;
					outcome_seen[result.data.outcome]++;
					if (result.data.out_of_range)
						flagged_seen++;
					if (result.data.bin_index_0 !== exp_r.bin_index_0) begin
						$display("%0t: bin_index_0 exp %0d got %0d", $time,
							exp_r.bin_index_0, result.data.bin_index_0);
						errors++;
					end
					if (result.data.bin_index_1 !== exp_r.bin_index_1) begin
						$display("%0t: bin_index_1 exp %0d got %0d", $time,
							exp_r.bin_index_1, result.data.bin_index_1);
						errors++;
					end
					if (result.data.sample_weight !== exp_r.sample_weight) begin
						$display("%0t: sample_weight exp %0d got %0d", $time,
							exp_r.sample_weight, result.data.sample_weight);
						errors++;
					end
					if (result.data.outcome !== exp_r.outcome) begin
						$display("%0t: outcome exp %0d got %0d", $time,
							exp_r.outcome, result.data.outcome);
						errors++;
					end
					if (result.data.out_of_range !== exp_r.out_of_range) begin
						$display("%0t: out_of_range exp %0d got %0d", $time,
							exp_r.out_of_range, result.data.out_of_range);
						errors++;
					end
					if (result.data.cells_held !== exp_r.cells_held) begin
						$display("%0t: cells_held exp %0d got %0d", $time,
							exp_r.cells_held, result.data.cells_held);
						errors++;
					end
					if (result.data.worst_weight !== exp_r.worst_weight) begin
						$display("%0t: worst_weight exp %0d got %0d", $time,
							exp_r.worst_weight, result.data.worst_weight);
						errors++;
					end
				end
			end
			if (stall_phase == 0) begin
				stall_phase <= $urandom_range(50, 400);
				stall_mode <= $urandom_range(0, 1);
			end else begin
				stall_phase <= stall_phase - 1;
			end
			if (long_stall_req && long_stall_left == 0) begin
				long_stall_left <= 2000;
				result.ready <= 1'b0;
			end else if (long_stall_left != 0) begin
				long_stall_left <= long_stall_left - 1;
				result.ready <= (long_stall_left == 1);
			end else if (stall_mode) begin
				result.ready <= ($urandom_range(0, 3) != 0);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	task automatic send_sample(logic [31:0] c0, logic [31:0] c1, logic [31:0] meas);
		sample_t s;
		s.coord_0 = c0;
		s.coord_1 = c1;
		s.measured = meas;
		sample.valid <= 1'b1;
		sample.data <= s;
		do @(posedge clk); while (!sample.ready);
		pending_results.insert(pending_results.size(), track_cell(s));
		beats_sent++;
		if (burst_left == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_drained();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_LOWER_0: edge_lo[0] = value;
			REG_UPPER_0: edge_hi[0] = value;
			REG_LOWER_1: edge_lo[1] = value;
			REG_UPPER_1: edge_hi[1] = value;
			REG_TARGET: target_q16 = value;
			REG_NBINS: bin_count = value[10:0];
			REG_LIMIT: keep_limit = value[4:0];
			REG_DIMS: dim_count = value[1:0];
			default: ;
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_bounds(logic [31:0] lo0, logic [31:0] hi0, logic [31:0] lo1,
			logic [31:0] hi1);
		write_reg(REG_LOWER_0, lo0);
		write_reg(REG_UPPER_0, hi0);
		write_reg(REG_LOWER_1, lo1);
		write_reg(REG_UPPER_1, hi1);
	endtask

	task automatic test_edges();
		send_sample(32'd0, 32'd0, 32'd65536);
		send_sample(32'hFFFF_FFFF, 32'd100, 32'd65536);
		send_sample(32'd65537, 32'd65536, 32'd32768);
		send_sample(32'd65536, 32'd1, 32'd0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
		set_bounds(32'h8000_0000, 32'h7FFF_FFFF, 32'd5000, 32'd5000);
		send_sample(32'h8000_0000, 32'd5000, 32'd70000);
		send_sample(32'h7FFF_FFFF, 32'd4999, 32'd1);
		wait_drained();
	endtask

	task automatic test_dims_bins();
		set_bounds(32'd0, 32'd65536, 32'd0, 32'd65536);
		write_reg(REG_NBINS, 32'd0);
		write_reg(REG_DIMS, 32'd0);
		send_sample(32'd40000, 32'd40000, 32'd65536);
		wait_drained();
		write_reg(REG_NBINS, 32'd2047);
		write_reg(REG_DIMS, 32'd3);
		send_sample(32'd65535, 32'd1, 32'd65536);
		send_sample(32'd70000, 32'd32768, 32'd65536);
		wait_drained();
		write_reg(REG_NBINS, 32'd1024);
		write_reg(REG_DIMS, 32'd1);
		send_sample(32'd64, 32'h1234_5678, 32'd65536);
		wait_drained();
		write_reg(REG_DIMS, 32'd2);
	endtask

	task automatic test_weights();
		write_reg(REG_TARGET, 32'd0);
		send_sample(32'd0, 32'd0, 32'd0);
		send_sample(32'd0, 32'd0, 32'd7);
		wait_drained();
		write_reg(REG_TARGET, 32'hFFFF_FFFF);
		send_sample(32'd100, 32'd0, 32'hFFFF_FFFF);
		send_sample(32'd200, 32'd0, 32'd1);
		wait_drained();
		write_reg(REG_TARGET, 32'd1);
		send_sample(32'd300, 32'd0, 32'd2);
		wait_drained();
		write_reg(REG_TARGET, 32'd65536);
	endtask

	task automatic test_table_limit();
		write_reg(REG_NBINS, 32'd16);
		write_reg(REG_LIMIT, 32'd0);
		send_sample(32'd4096, 32'd0, 32'd30000);
		send_sample(32'd8192, 32'd0, 32'd60000);
		send_sample(32'd12288, 32'd0, 32'd60000);
		wait_drained();
		write_reg(REG_LIMIT, 32'd31);
		for (int i = 0; i < 4; i++)
			send_sample(32'(i * 4096 + 20000), 32'd20000, 32'(30000 + i * 5000));
		wait_drained();
		write_reg(REG_LIMIT, 32'd2);
		send_sample(32'd60000, 32'd60000, 32'd65536);
		send_sample(32'd60000, 32'd50000, 32'd10);
		wait_drained();
		write_reg(REG_LIMIT, 32'd16);
	endtask

	task automatic test_backpressure();
		long_stall_req <= 1'b1;
		@(posedge clk);
		long_stall_req <= 1'b0;
		for (int i = 0; i < 8; i++)
			send_sample($urandom, $urandom, $urandom_range(0, 131072));
		wait_drained();
	endtask

	function automatic logic [31:0] coord_near(logic [31:0] lo, logic [31:0] hi);
		longint l, h, span, c;
		l = longint'($signed(lo));
		h = longint'($signed(hi));
		span = (h > l) ? h - l : 64;
		c = l - span / 8 + longint'({$urandom, $urandom} % (span + span / 4 + 1));
		if ($urandom_range(0, 15) == 0)
			c = l;
		return 32'(c);
	endfunction

	task automatic test_random(int unsigned phases, int unsigned per_phase);
		logic [31:0] lo, span;
		for (int p = 0; p < phases; p++) begin
			for (int d = 0; d < 2; d++) begin
				case ($urandom_range(0, 5))
					0: begin
						lo = 32'h8000_0000;
						span = 32'hFFFF_FFFF;
					end
					1: begin
						lo = $urandom;
						span = ($urandom_range(0, 1)) ? 32'd0 : 32'hFFFF_FFF0;
					end
					default: begin
						lo = $urandom_range(0, 200000) - 100000;
						span = $urandom_range(1, 400000);
					end
				endcase
				write_reg((d == 0) ? REG_LOWER_0 : REG_LOWER_1, lo);
				write_reg((d == 0) ? REG_UPPER_0 : REG_UPPER_1, lo + span);
			end
			write_reg(REG_TARGET, ($urandom_range(0, 7) == 0) ? $urandom
				: $urandom_range(1000, 300000));
			write_reg(REG_NBINS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2047)
				: $urandom_range(1, 6));
			write_reg(REG_LIMIT, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
				: $urandom_range(1, 16));
			write_reg(REG_DIMS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3)
				: $urandom_range(1, 2));
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(0, 6) == 0)
					send_sample($urandom, $urandom, $urandom);
				else
					send_sample(coord_near(edge_lo[0], edge_hi[0]),
						coord_near(edge_lo[1], edge_hi[1]),
						32'(longint'(target_q16) * $urandom_range(0, 400) / 200));
			end
			wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.data = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.wdata = '0;
		long_stall_req = 1'b0;
		edge_lo[0] = 32'd0;
		edge_hi[0] = 32'd65536;
		edge_lo[1] = 32'd0;
		edge_hi[1] = 32'd65536;
		target_q16 = 32'd65536;
		bin_count = 11'd16;
		keep_limit = 5'd16;
		dim_count = 2'd2;
		for (int i = 0; i < 16; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_weight[i] = '0;
		end
		held = 0;
		low_slot = 0;
		low_weight = FULL_WEIGHT;
		errors = 0;
		results_seen = 0;
		flagged_seen = 0;
		beats_sent = 0;
		outcome_seen = '{default: 0};
		burst_left = 4;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges();
		test_dims_bins();
		test_weights();
		test_table_limit();
		test_backpressure();
		test_random(6, 250);
		sample.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("sent %0d samples, checked %0d results, %0d out of range",
			beats_sent, results_seen, flagged_seen);
		$display("outcomes kept/inserted/replaced/discarded: %0d/%0d/%0d/%0d",
			outcome_seen[OUT_KEPT], outcome_seen[OUT_INSERTED],
			outcome_seen[OUT_REPLACED], outcome_seen[OUT_DISCARDED]);
		if (errors == 0 && pending_results.size() == 0)
			$display("grid_cell_top_n_tracker test passed");
		else
			$display("grid_cell_top_n_tracker test failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
rtl/gct_pkg.sv
rtl/gct_if.sv
rtl/gct_front.sv
rtl/gct_queue.sv
rtl/gct_back.sv
rtl/grid_cell_top_n_tracker.sv
verif/testbench.sv
